@@ rtl/assert_macros.svh @@
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define GRO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked on every clock edge, reset included
`define GRO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/gro_pkg.sv @@
// shared types, codes and helper functions of the grid occupancy allocator
`timescale 1ns / 1ps
`default_nettype none

package gro_pkg;

  // signed working width for corners, sizes and grid bounds
  localparam int CALC_W = 8;
  // widest row word any configuration may use
  localparam int MASK_W = 64;

  typedef logic signed [CALC_W-1:0] calc_t;

  typedef enum logic [1:0] {
    FUNC_TEST   = 2'd0,
    FUNC_OCCUPY = 2'd1,
    FUNC_FREE   = 2'd2,
    FUNC_FIND   = 2'd3
  } func_t;

  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  function automatic calc_t sext5(logic [4:0] v);
    return {{(CALC_W-5){v[4]}}, v};
  endfunction

  function automatic calc_t zext5(logic [4:0] v);
    return {{(CALC_W-5){1'b0}}, v};
  endfunction

  // bits lo up to but not including hi
  function automatic logic [MASK_W-1:0] span_mask(calc_t lo, calc_t hi);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int i = 0; i < MASK_W; i++) begin
      m[i] = (calc_t'(i) >= lo) && (calc_t'(i) < hi);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/gro_rowmem.sv @@
// occupancy row memory with one read and one write port and per-row valid bits
`timescale 1ns / 1ps
`default_nettype none

module gro_rowmem #(
  parameter int MAX_COLS = 16,
  parameter int MAX_ROWS = 16,
  parameter int RAW      = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire gro_pkg::mem_ctl_t    ctl,
  input  wire logic [RAW-1:0]       rd_addr,
  input  wire logic [RAW-1:0]       wr_addr,
  input  wire logic [MAX_COLS-1:0]  wr_data,
  output logic [MAX_COLS-1:0]       rd_data
);

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_vld_r;
  logic [MAX_COLS-1:0] rd_data_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // unwritten rows read as free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld_r <= row_vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

@@ rtl/gro_colfit.sv @@
// first-fit column search of a free window in one merged row word
`timescale 1ns / 1ps
`default_nettype none

module gro_colfit #(
  parameter int MAX_COLS = 16,
  parameter int CXW      = 4
) (
  input  wire logic [MAX_COLS-1:0] acc,
  input  wire gro_pkg::calc_t      size_x,
  input  wire gro_pkg::calc_t      width,
  output logic                     hit,
  output logic [CXW-1:0]           col
);

  logic [MAX_COLS-1:0] ok;

  always_comb begin
    logic [gro_pkg::MASK_W-1:0] win;
    ok = '0;
    for (int x = 0; x < MAX_COLS; x++) begin
      win   = gro_pkg::span_mask(gro_pkg::calc_t'(x), gro_pkg::calc_t'(x) + size_x);
      ok[x] = (gro_pkg::calc_t'(x) + size_x <= width) &&
              ((win[MAX_COLS-1:0] & acc) == '0);
    end
  end

  // lowest fitting column wins
  always_comb begin
    hit = 1'b0;
    col = '0;
    for (int x = MAX_COLS - 1; x >= 0; x--) begin
      if (ok[x]) begin
        hit = 1'b1;
        col = CXW'(x);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/grid_rect_occupancy_allocator_top.sv @@
// top level of the grid rectangle occupancy allocator
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// sequence: a rejected test or find answers at once, a zero-size test or find
//   goes straight to judging, test scans its rows then judges, occupy or free
//   reads and writes back each clipped row, find scans each candidate row in turn
// throughput: one item at a time, next start taken on the cycle of the result
// pace set by the single read port of the row memory, one row word a cycle while scanning
// reset: grid 16 by 16, all cells free at once through per-row valid bits,
//   no result pending; results cannot be stalled by the receiver
module grid_rect_occupancy_allocator_top #(
  parameter int MAX_COLS = 16,
  parameter int MAX_ROWS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // item channel
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_func,
  input  wire logic signed [4:0] in_pos_x,
  input  wire logic signed [4:0] in_pos_y,
  input  wire logic [4:0]        in_size_x,
  input  wire logic [4:0]        in_size_y,
  // result channel
  output logic                   out_valid,
  output logic                   out_fits,
  output logic                   out_found,
  output logic [3:0]             out_found_x,
  output logic [3:0]             out_found_y,
  // configuration channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [4:0]        cfg_data
);

  localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CXW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam gro_pkg::calc_t MAX_COLS_C = gro_pkg::calc_t'(MAX_COLS);
  localparam gro_pkg::calc_t MAX_ROWS_C = gro_pkg::calc_t'(MAX_ROWS);
  localparam gro_pkg::calc_t ONE_C      = gro_pkg::calc_t'(1);
  localparam gro_pkg::calc_t ZERO_C     = gro_pkg::calc_t'(0);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,   // stream row reads, merge returning words
    ST_LAST,   // merge the final returning word
    ST_EVAL,   // judge the merged word
    ST_RD,     // read one row for update
    ST_WR      // write the updated row back
  } state_t;

  state_t              state_r, state_nxt;
  gro_pkg::func_t      func_r, func_nxt;
  gro_pkg::calc_t      sx_r, sx_nxt;
  gro_pkg::calc_t      sy_r, sy_nxt;
  gro_pkg::calc_t      w_r, w_nxt;
  gro_pkg::calc_t      h_r, h_nxt;
  gro_pkg::calc_t      addr_r, addr_nxt;
  gro_pkg::calc_t      cnt_r, cnt_nxt;
  gro_pkg::calc_t      cand_r, cand_nxt;
  logic [MAX_COLS-1:0] mask_r, mask_nxt;
  logic [MAX_COLS-1:0] acc_r, acc_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_fits_r, out_fits_nxt;
  logic                out_found_r, out_found_nxt;
  logic [3:0]          out_found_x_r, out_found_x_nxt;
  logic [3:0]          out_found_y_r, out_found_y_nxt;
  logic [4:0]          grid_width_r;
  logic [4:0]          grid_height_r;

  // item fields decoded on acceptance
  gro_pkg::calc_t px, py, sx, sy, w, h, xe, ye, x0, x1, y0, y1;
  logic [gro_pkg::MASK_W-1:0] test_span, write_span;

  // memory side
  gro_pkg::mem_ctl_t   mem_ctl;
  logic [RAW-1:0]      mem_addr;
  logic [MAX_COLS-1:0] mem_wr_data;
  logic [MAX_COLS-1:0] rd_row;
  logic [MAX_COLS-1:0] acc_in;

  // column search
  logic           fit_hit;
  logic [CXW-1:0] fit_col;
  gro_pkg::calc_t fit_col_c;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign px = gro_pkg::sext5(in_pos_x);
  assign py = gro_pkg::sext5(in_pos_y);
  assign sx = gro_pkg::zext5(in_size_x);
  assign sy = gro_pkg::zext5(in_size_y);
  // grid clipped to the storage
  assign w  = (gro_pkg::zext5(grid_width_r) < MAX_COLS_C) ?
              gro_pkg::zext5(grid_width_r) : MAX_COLS_C;
  assign h  = (gro_pkg::zext5(grid_height_r) < MAX_ROWS_C) ?
              gro_pkg::zext5(grid_height_r) : MAX_ROWS_C;
  assign xe = px + sx;
  assign ye = py + sy;
  // occupy and free skip cells outside the grid
  assign x0 = (px < ZERO_C) ? ZERO_C : px;
  assign x1 = (xe > w) ? w : xe;
  assign y0 = (py < ZERO_C) ? ZERO_C : py;
  assign y1 = (ye > h) ? h : ye;

  assign test_span  = gro_pkg::span_mask(px, xe);
  assign write_span = gro_pkg::span_mask(x0, x1);

  assign acc_in      = acc_r | (pend_r ? rd_row : '0);
  assign mem_addr    = addr_r[RAW-1:0];
  assign mem_wr_data = (func_r == gro_pkg::FUNC_OCCUPY) ? (rd_row | mask_r)
                                                        : (rd_row & ~mask_r);
  assign fit_col_c   = gro_pkg::calc_t'(fit_col);

  gro_rowmem #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .RAW      (RAW)
  ) u_rowmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .rd_addr (mem_addr),
    .wr_addr (mem_addr),
    .wr_data (mem_wr_data),
    .rd_data (rd_row)
  );

  gro_colfit #(
    .MAX_COLS (MAX_COLS),
    .CXW      (CXW)
  ) u_colfit (
    .acc    (acc_r),
    .size_x (sx_r),
    .width  (w_r),
    .hit    (fit_hit),
    .col    (fit_col)
  );

  always_comb begin
    state_nxt       = state_r;
    func_nxt        = func_r;
    sx_nxt          = sx_r;
    sy_nxt          = sy_r;
    w_nxt           = w_r;
    h_nxt           = h_r;
    addr_nxt        = addr_r;
    cnt_nxt         = cnt_r;
    cand_nxt        = cand_r;
    mask_nxt        = mask_r;
    acc_nxt         = acc_r;
    pend_nxt        = 1'b0;
    out_valid_nxt   = 1'b0;
    out_fits_nxt    = out_fits_r;
    out_found_nxt   = out_found_r;
    out_found_x_nxt = out_found_x_r;
    out_found_y_nxt = out_found_y_r;
    mem_ctl         = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          func_nxt        = gro_pkg::func_t'(in_func);
          sx_nxt          = sx;
          sy_nxt          = sy;
          w_nxt           = w;
          h_nxt           = h;
          acc_nxt         = '0;
          cand_nxt        = '0;
          out_fits_nxt    = 1'b0;
          out_found_nxt   = 1'b0;
          out_found_x_nxt = '0;
          out_found_y_nxt = '0;
          case (gro_pkg::func_t'(in_func))
            gro_pkg::FUNC_TEST: begin
              mask_nxt = test_span[MAX_COLS-1:0];
              addr_nxt = py;
              cnt_nxt  = sy;
              if (px < ZERO_C || py < ZERO_C || xe > w || ye > h) begin
                out_valid_nxt = 1'b1;
              end else if (sy == '0) begin
                state_nxt = ST_EVAL;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            gro_pkg::FUNC_OCCUPY, gro_pkg::FUNC_FREE: begin
              mask_nxt = write_span[MAX_COLS-1:0];
              addr_nxt = y0;
              cnt_nxt  = y1 - y0;
              if (y0 >= y1) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_RD;
              end
            end
            default: begin
              // find, first candidate row is the top one
              addr_nxt = '0;
              cnt_nxt  = sy;
              if (sx > w || sy > h) begin
                out_valid_nxt = 1'b1;
              end else if (sy == '0) begin
                state_nxt = ST_EVAL;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
          endcase
        end
      end

      ST_SCAN: begin
        mem_ctl.rd_en = 1'b1;
        pend_nxt      = 1'b1;
        acc_nxt       = acc_in;
        addr_nxt      = addr_r + ONE_C;
        cnt_nxt       = cnt_r - ONE_C;
        if (cnt_r == ONE_C) begin
          state_nxt = ST_LAST;
        end
      end

      ST_LAST: begin
        acc_nxt   = acc_in;
        state_nxt = ST_EVAL;
      end

      ST_EVAL: begin
        case (func_r)
          gro_pkg::FUNC_TEST: begin
            out_fits_nxt  = ((acc_r & mask_r) == '0);
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
          default: begin
            if (fit_hit) begin
              out_found_nxt   = 1'b1;
              out_found_x_nxt = fit_col_c[3:0];
              out_found_y_nxt = cand_r[3:0];
              out_valid_nxt   = 1'b1;
              state_nxt       = ST_IDLE;
            end else if (cand_r + ONE_C + sy_r <= h_r) begin
              // slide the window one row down and merge again
              cand_nxt  = cand_r + ONE_C;
              addr_nxt  = cand_r + ONE_C;
              cnt_nxt   = sy_r;
              acc_nxt   = '0;
              state_nxt = ST_SCAN;
            end else begin
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
        endcase
      end

      ST_RD: begin
        mem_ctl.rd_en = 1'b1;
        state_nxt     = ST_WR;
      end

      ST_WR: begin
        mem_ctl.wr_en = 1'b1;
        addr_nxt      = addr_r + ONE_C;
        cnt_nxt       = cnt_r - ONE_C;
        if (cnt_r == ONE_C) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_RD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      grid_width_r  <= 5'd16;
      grid_height_r <= 5'd16;
    end else begin
      state_r       <= state_nxt;
      pend_r        <= pend_nxt;
      out_valid_r   <= out_valid_nxt;
      func_r        <= func_nxt;
      sx_r          <= sx_nxt;
      sy_r          <= sy_nxt;
      w_r           <= w_nxt;
      h_r           <= h_nxt;
      addr_r        <= addr_nxt;
      cnt_r         <= cnt_nxt;
      cand_r        <= cand_nxt;
      mask_r        <= mask_nxt;
      acc_r         <= acc_nxt;
      out_fits_r    <= out_fits_nxt;
      out_found_r   <= out_found_nxt;
      out_found_x_r <= out_found_x_nxt;
      out_found_y_r <= out_found_y_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gro_pkg::CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
          gro_pkg::CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_fits    = out_fits_r;
  assign out_found   = out_found_r;
  assign out_found_x = out_found_x_r;
  assign out_found_y = out_found_y_r;

  // an accepted item either answers at once or keeps the block busy
  `GRO_ASSERT(a_accept_progress, start && !busy |=> busy || out_valid, "item lost")
  // a result is only shown once the sequencer is back at rest
  `GRO_ASSERT(a_result_idle, out_valid |-> !busy, "result while busy")
  // the row memory is never read while it is being written
  `GRO_ASSERT(a_mem_port, mem_ctl.wr_en |-> !mem_ctl.rd_en, "read during write")
  // a result without a found position reports the origin
  `GRO_ASSERT(a_notfound_zero,
    out_valid && !out_found |-> out_found_x == '0 && out_found_y == '0,
    "not-found result carries a position")
  // reset leaves no result and an idle sequencer
  `GRO_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && !busy, "reset not clean")

endmodule

`default_nettype wire
